FILE: design/mav_pkg.sv
// Shared types and constants for the multi-turn encoder angle/velocity block.
// No dependencies; imported by every other module in this folder.
package mav_pkg;

    localparam int TURN_W       = 12;   // signed turn counter
    localparam int LAST_ANGLE_W = 25;   // stored angle at last velocity read, mod 2^25
    localparam int THRESH_W     = 12;
    localparam int LIMIT_W      = 11;
    localparam int TIME_W       = 32;
    localparam int ANGLE_W      = 24;
    localparam int VEL_W        = 32;
    localparam int DIV_CNT_W    = 5;    // counts the 32 quotient bits

    localparam int US_PER_S_W = 20;
    localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;

    localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

    localparam logic [THRESH_W-1:0] WRAP_THRESHOLD_RST = 12'd3277;
    localparam logic [LIMIT_W-1:0]  TURN_LIMIT_RST     = 11'd2000;
    localparam logic [TIME_W-1:0]   MAX_INTERVAL_RST   = 32'd500000;
    localparam logic [TIME_W-1:0]   FALLBACK_RST       = 32'd1000;

    typedef enum logic [1:0] {
        ACT_INIT     = 2'd0,
        ACT_ANGLE    = 2'd1,
        ACT_VELOCITY = 2'd2,
        ACT_HOLD     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_WRAP_THRESHOLD = 2'd0,
        REG_TURN_LIMIT     = 2'd1,
        REG_MAX_INTERVAL   = 2'd2,
        REG_FALLBACK       = 2'd3
    } cfg_idx_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [VEL_W-1:0] quo;
    } div_res_t;

endpackage

FILE: design/mav_unwrap.sv
// Turn unwrap step: wrap detection, turn counter update and limit clearing.
// Depends on mav_pkg. Purely combinational; the sequencer registers the results.
module mav_unwrap #(
    parameter int RAW_BITS = 12,
    parameter int ANG_W    = 25
) (
    input  logic [RAW_BITS-1:0]                       raw,
    input  logic [RAW_BITS-1:0]                       last_raw,
    input  logic signed [mav_pkg::TURN_W-1:0]         turn,
    input  logic [mav_pkg::LAST_ANGLE_W-1:0]          last_angle,
    input  logic [mav_pkg::THRESH_W-1:0]              wrap_threshold,
    input  logic [mav_pkg::LIMIT_W-1:0]               turn_limit,
    output logic signed [mav_pkg::TURN_W-1:0]         turn_out,
    output logic [mav_pkg::LAST_ANGLE_W-1:0]          last_angle_out,
    output logic signed [ANG_W-1:0]                   ang
);
    import mav_pkg::*;

    localparam int CMP_W = (RAW_BITS + 1 > THRESH_W) ? RAW_BITS + 1 : THRESH_W;

    logic signed [RAW_BITS:0]   delta;
    logic [RAW_BITS:0]          delta_mag;
    logic                       wrapped;
    logic signed [TURN_W-1:0]   turn_inc;
    logic signed [TURN_W-1:0]   lim;
    logic                       hit_pos;
    logic                       hit_neg;
    logic [LAST_ANGLE_W-1:0]    shift;

    always_comb
    begin
        delta     = signed'({1'b0, raw}) - signed'({1'b0, last_raw});
        delta_mag = delta[RAW_BITS] ? unsigned'(-delta) : unsigned'(delta);
        wrapped   = CMP_W'(delta_mag) >= CMP_W'(wrap_threshold);

        // forward jump means the sample wrapped backward, and the other way round
        if (!wrapped)
            turn_inc = turn;
        else if (delta > 0)
            turn_inc = turn - TURN_W'(1);
        else
            turn_inc = turn + TURN_W'(1);

        lim     = signed'({1'b0, turn_limit});
        hit_pos = turn_inc >= lim;
        hit_neg = turn_inc <= -lim;
        shift   = LAST_ANGLE_W'({turn_limit, {RAW_BITS{1'b0}}});

        turn_out = (hit_pos || hit_neg) ? '0 : turn_inc;

        // keep the velocity reference in the same frame as the cleared counter
        if (hit_pos)
            last_angle_out = last_angle - shift;
        else if (hit_neg)
            last_angle_out = last_angle + shift;
        else
            last_angle_out = last_angle;

        ang = (ANG_W'(turn_out) <<< RAW_BITS) + ANG_W'(raw);
    end

endmodule

FILE: design/mav_divider.sv
// Iterative restoring divider, one quotient bit per cycle, 32-bit quotient.
// Depends on mav_pkg. Flags overflow up front when the quotient needs more than 32 bits.
module mav_divider #(
    parameter int NUM_W = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_W-1:0]              num,
    input  logic [mav_pkg::VEL_W-1:0]     den,
    output mav_pkg::div_res_t             res
);
    import mav_pkg::*;

    localparam int HI_W = NUM_W - VEL_W;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  ovf_reg, ovf_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VEL_W-1:0]      rem_reg, rem_next;
    logic [VEL_W-1:0]      quo_reg, quo_next;
    logic [VEL_W:0]        trial;
    logic [HI_W-1:0]       num_hi;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        num_hi    = num[NUM_W-1:VEL_W];
        trial     = {rem_reg, quo_reg[VEL_W-1]} - {1'b0, den};

        if (start)
        begin
            ovf_next = VEL_W'(num_hi) >= den;
            rem_next = VEL_W'(num_hi);
            quo_next = num[VEL_W-1:0];
            cnt_next = '1;
            if (VEL_W'(num_hi) >= den)
                done_next = 1'b1;
            else
                busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // quo_reg shifts numerator bits out at the top and quotient bits in below
            if (!trial[VEL_W])
                rem_next = trial[VEL_W-1:0];
            else
                rem_next = {rem_reg[VEL_W-2:0], quo_reg[VEL_W-1]};
            quo_next = {quo_reg[VEL_W-2:0], ~trial[VEL_W]};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = quo_reg;

endmodule

FILE: design/encoder_multiturn_angle_velocity.sv
// Multi-turn absolute encoder unwrapper with velocity estimate (top level).
// Depends on mav_pkg, mav_unwrap and mav_divider.
//
// One request at a time: in_stall is high from the cycle after a request is
// taken until its result has moved into the output register. Initialize, angle
// read and hold pass through the execute and output states. A velocity read
// also passes the difference, multiply, divider start and divider wait states,
// the serial divider producing one quotient bit per cycle; when the quotient is
// known to overflow up front the divider reports done without iterating. A new
// request is taken while the previous result still waits on out_stall.
// Configuration writes are always accepted and take effect at once; write them
// only while no request is open. Velocity is counts per second truncated toward
// zero and clipped to 32 bits with velocity_saturated set.
module encoder_multiturn_angle_velocity #(
    parameter int RAW_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [31:0]                           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            action,
    input  logic [RAW_BITS-1:0]                   raw_count,
    input  logic [mav_pkg::TIME_W-1:0]            time_us,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mav_pkg::ANGLE_W-1:0]    angle,
    output logic signed [mav_pkg::VEL_W-1:0]      velocity,
    output logic                                  velocity_saturated
);
    import mav_pkg::*;

    localparam int ANG_W  = RAW_BITS + TURN_W + 1;
    localparam int DIFF_W = ((ANG_W > LAST_ANGLE_W) ? ANG_W : LAST_ANGLE_W) + 1;
    localparam int NUM_W  = DIFF_W + US_PER_S_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EXEC   = 7'b0000010,
        ST_DIFF   = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_DSTART = 7'b0010000,
        ST_DWAIT  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t                     state_reg, state_next;
    action_t                    act_reg, act_next;
    logic [RAW_BITS-1:0]        raw_reg, raw_next;
    logic [TIME_W-1:0]          time_reg, time_next;

    logic [THRESH_W-1:0]        wrap_thr_reg, wrap_thr_next;
    logic [LIMIT_W-1:0]         turn_lim_reg, turn_lim_next;
    logic [TIME_W-1:0]          max_int_reg, max_int_next;
    logic [TIME_W-1:0]          fb_int_reg, fb_int_next;

    logic [RAW_BITS-1:0]        last_raw_reg, last_raw_next;
    logic signed [TURN_W-1:0]   turn_reg, turn_next;
    logic [LAST_ANGLE_W-1:0]    last_angle_reg, last_angle_next;
    logic [TIME_W-1:0]          last_time_reg, last_time_next;

    logic signed [ANG_W-1:0]    ang_reg, ang_next;
    logic [TIME_W-1:0]          dt_reg, dt_next;
    logic                       neg_reg, neg_next;
    logic [DIFF_W-1:0]          mag_reg, mag_next;
    logic [NUM_W-1:0]           num_reg, num_next;
    logic [VEL_W-1:0]           vel_reg, vel_next;
    logic                       sat_reg, sat_next;

    logic                       out_valid_reg, out_valid_next;
    logic [ANGLE_W-1:0]         angle_out_reg, angle_out_next;
    logic [VEL_W-1:0]           vel_out_reg, vel_out_next;
    logic                       sat_out_reg, sat_out_next;

    logic signed [TURN_W-1:0]   unw_turn;
    logic [LAST_ANGLE_W-1:0]    unw_last_angle;
    logic signed [ANG_W-1:0]    unw_ang;
    logic [TIME_W-1:0]          dt_meas;
    logic [TIME_W-1:0]          dt_sel;
    logic signed [DIFF_W-1:0]   diff;
    logic                       accept;
    logic                       div_start;
    div_res_t                   div_res;

    mav_unwrap #(
        .RAW_BITS (RAW_BITS),
        .ANG_W    (ANG_W)
    ) u_unwrap (
        .raw            (raw_reg),
        .last_raw       (last_raw_reg),
        .turn           (turn_reg),
        .last_angle     (last_angle_reg),
        .wrap_threshold (wrap_thr_reg),
        .turn_limit     (turn_lim_reg),
        .turn_out       (unw_turn),
        .last_angle_out (unw_last_angle),
        .ang            (unw_ang)
    );

    mav_divider #(
        .NUM_W (NUM_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (dt_reg),
        .res   (div_res)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign div_start = (state_reg == ST_DSTART);

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        raw_next        = raw_reg;
        time_next       = time_reg;
        wrap_thr_next   = wrap_thr_reg;
        turn_lim_next   = turn_lim_reg;
        max_int_next    = max_int_reg;
        fb_int_next     = fb_int_reg;
        last_raw_next   = last_raw_reg;
        turn_next       = turn_reg;
        last_angle_next = last_angle_reg;
        last_time_next  = last_time_reg;
        ang_next        = ang_reg;
        dt_next         = dt_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        num_next        = num_reg;
        vel_next        = vel_reg;
        sat_next        = sat_reg;
        out_valid_next  = out_valid_reg;
        angle_out_next  = angle_out_reg;
        vel_out_next    = vel_out_reg;
        sat_out_next    = sat_out_reg;

        dt_meas = time_reg - last_time_reg;
        dt_sel  = (dt_meas == '0 || dt_meas > max_int_reg) ? fb_int_reg : dt_meas;
        diff    = DIFF_W'(ang_reg) - DIFF_W'(signed'(last_angle_reg));

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_WRAP_THRESHOLD: wrap_thr_next = cfg_data[THRESH_W-1:0];
                REG_TURN_LIMIT:     turn_lim_next = cfg_data[LIMIT_W-1:0];
                REG_MAX_INTERVAL:   max_int_next  = cfg_data;
                REG_FALLBACK:       fb_int_next   = cfg_data;
                default:            ;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action_t'(action);
                    raw_next   = raw_count;
                    time_next  = time_us;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                vel_next   = '0;
                sat_next   = 1'b0;
                state_next = ST_OUT;
                unique case (act_reg)
                    ACT_INIT:
                    begin
                        last_raw_next   = raw_reg;
                        turn_next       = '0;
                        last_time_next  = time_reg;
                        last_angle_next = LAST_ANGLE_W'(raw_reg);
                        ang_next        = ANG_W'(raw_reg);
                    end
                    ACT_ANGLE:
                    begin
                        last_raw_next   = raw_reg;
                        turn_next       = unw_turn;
                        last_angle_next = unw_last_angle;
                        ang_next        = unw_ang;
                    end
                    ACT_VELOCITY:
                    begin
                        // interval is measured before the unwrap touches anything
                        dt_next         = (dt_sel == '0) ? TIME_W'(1) : dt_sel;
                        last_raw_next   = raw_reg;
                        turn_next       = unw_turn;
                        last_angle_next = unw_last_angle;
                        ang_next        = unw_ang;
                        state_next      = ST_DIFF;
                    end
                    ACT_HOLD:
                    begin
                        ang_next = (ANG_W'(turn_reg) <<< RAW_BITS) + ANG_W'(last_raw_reg);
                    end
                    default: ;
                endcase
            end

            ST_DIFF:
            begin
                neg_next        = diff[DIFF_W-1];
                mag_next        = diff[DIFF_W-1] ? unsigned'(-diff) : unsigned'(diff);
                last_angle_next = LAST_ANGLE_W'(ang_reg);
                last_time_next  = time_reg;
                state_next      = ST_MUL;
            end

            ST_MUL:
            begin
                num_next   = NUM_W'(mag_reg) * NUM_W'(US_PER_S);
                state_next = ST_DSTART;
            end

            ST_DSTART:
            begin
                state_next = ST_DWAIT;
            end

            ST_DWAIT:
            begin
                if (div_res.done)
                begin
                    // magnitude above 2^31 clips; exactly 2^31 is still legal when negative
                    if (div_res.ovf)
                    begin
                        sat_next = 1'b1;
                        vel_next = neg_reg ? VEL_MIN : VEL_MAX;
                    end
                    else if (!neg_reg)
                    begin
                        sat_next = div_res.quo[VEL_W-1];
                        vel_next = div_res.quo[VEL_W-1] ? VEL_MAX : div_res.quo;
                    end
                    else if (div_res.quo[VEL_W-1] && (|div_res.quo[VEL_W-2:0]))
                    begin
                        sat_next = 1'b1;
                        vel_next = VEL_MIN;
                    end
                    else
                    begin
                        sat_next = 1'b0;
                        vel_next = -div_res.quo;
                    end
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    angle_out_next = ANGLE_W'(ang_reg);
                    vel_out_next   = vel_reg;
                    sat_out_next   = sat_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            wrap_thr_reg   <= WRAP_THRESHOLD_RST;
            turn_lim_reg   <= TURN_LIMIT_RST;
            max_int_reg    <= MAX_INTERVAL_RST;
            fb_int_reg     <= FALLBACK_RST;
            last_raw_reg   <= '0;
            turn_reg       <= '0;
            last_angle_reg <= '0;
            last_time_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            wrap_thr_reg   <= wrap_thr_next;
            turn_lim_reg   <= turn_lim_next;
            max_int_reg    <= max_int_next;
            fb_int_reg     <= fb_int_next;
            last_raw_reg   <= last_raw_next;
            turn_reg       <= turn_next;
            last_angle_reg <= last_angle_next;
            last_time_reg  <= last_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        raw_reg       <= raw_next;
        time_reg      <= time_next;
        ang_reg       <= ang_next;
        dt_reg        <= dt_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        num_reg       <= num_next;
        vel_reg       <= vel_next;
        sat_reg       <= sat_next;
        angle_out_reg <= angle_out_next;
        vel_out_reg   <= vel_out_next;
        sat_out_reg   <= sat_out_next;
    end

    assign out_valid          = out_valid_reg;
    assign angle              = signed'(angle_out_reg);
    assign velocity           = signed'(vel_out_reg);
    assign velocity_saturated = sat_out_reg;

endmodule

FILE: dv/encoder_multiturn_angle_velocity_tb.sv
// Self-checking testbench for encoder_multiturn_angle_velocity: directed table, mostly
// hand-worked, then random phases under several register settings checked by an in-bench predictor.
// Depends on mav_pkg and the block's RTL only.
module encoder_multiturn_angle_velocity_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mav_pkg::*;

    localparam int     RAW_W        = 12;
    localparam longint CPR          = 4096;
    localparam longint US_PER_SEC   = 1000000;
    localparam longint INT32_TOP    = 64'sd2147483647;
    localparam longint INT32_BOTTOM = -64'sd2147483648;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     PHASE_ITEMS  = 105;
    localparam int     N_PHASES     = 6;
    localparam int     DRAIN_CYCLES = 60;
    localparam int     N_DIRECTED   = 25;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [VEL_W-1:0]   velocity;
        logic               saturated;
    } reading_t;

    typedef struct packed {
        action_t          act;
        logic [RAW_W-1:0] raw;
        logic [TIME_W-1:0] stamp;
        logic             fixed;
        reading_t         want;
    } vector_t;

    // Rows with fixed set carry a hand-worked result for the reset register values.
    localparam vector_t DIRECTED [N_DIRECTED] = '{
        '{ACT_HOLD,     12'hABC,  32'hDEADBEEF, 1'b1, '{24'd0,     32'd0,            1'b0}},
        '{ACT_INIT,     12'd100,  32'd1000,     1'b1, '{24'd100,   32'd0,            1'b0}},
        '{ACT_ANGLE,    12'd4095, 32'd1500,     1'b1, '{24'hFFFFFF, 32'd0,           1'b0}},
        '{ACT_ANGLE,    12'd0,    32'd1600,     1'b1, '{24'd0,     32'd0,            1'b0}},
        '{ACT_VELOCITY, 12'd0,    32'd1000,     1'b1, '{24'd0,     -32'sd100000,     1'b0}},
        '{ACT_VELOCITY, 12'd50,   32'd601000,   1'b1, '{24'd50,    32'd50000,        1'b0}},
        '{ACT_VELOCITY, 12'd150,  32'd601100,   1'b1, '{24'd150,   32'd1000000,      1'b0}},
        '{ACT_VELOCITY, 12'd4095, 32'd601101,   1'b1, '{24'hFFFFFF, -32'sd151000000, 1'b0}},
        '{ACT_ANGLE,    12'd0,    32'd601101,   1'b1, '{24'd0,     32'd0,            1'b0}},
        '{ACT_ANGLE,    12'd2100, 32'd601101,   1'b1, '{24'd2100,  32'd0,            1'b0}},
        '{ACT_VELOCITY, 12'd4095, 32'd601102,   1'b1, '{24'd4095,  VEL_MAX,          1'b1}},
        '{ACT_ANGLE,    12'd2000, 32'd601102,   1'b1, '{24'd2000,  32'd0,            1'b0}},
        '{ACT_ANGLE,    12'd0,    32'd601102,   1'b1, '{24'd0,     32'd0,            1'b0}},
        '{ACT_VELOCITY, 12'd0,    32'd601103,   1'b1, '{24'd0,     VEL_MIN,          1'b1}},
        '{ACT_INIT,     12'd10,   32'hFFFFFFF0, 1'b1, '{24'd10,    32'd0,            1'b0}},
        '{ACT_VELOCITY, 12'd20,   32'h00000010, 1'b1, '{24'd20,    32'd312500,       1'b0}},
        '{ACT_VELOCITY, 12'd13,   32'h00000013, 1'b1, '{24'd13,    -32'sd2333333,    1'b0}},
        '{ACT_INIT,     12'd4095, 32'hFFFFFFFF, 1'b1, '{24'd4095,  32'd0,            1'b0}},
        '{ACT_VELOCITY, 12'd4000, 32'd499999,   1'b1, '{24'd4000,  -32'sd190,        1'b0}},
        '{ACT_VELOCITY, 12'd4090, 32'd1000000,  1'b1, '{24'd4090,  32'd90000,        1'b0}},
        '{ACT_HOLD,     12'd0,    32'd0,        1'b1, '{24'd4090,  32'd0,            1'b0}},
        '{ACT_ANGLE,    12'd4095, 32'd0,        1'b0, '{24'd0,     32'd0,            1'b0}},
        '{ACT_ANGLE,    12'd818,  32'd0,        1'b0, '{24'd0,     32'd0,            1'b0}},
        '{ACT_ANGLE,    12'd4095, 32'd0,        1'b0, '{24'd0,     32'd0,            1'b0}},
        '{ACT_ANGLE,    12'd819,  32'd0,        1'b0, '{24'd0,     32'd0,            1'b0}}
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index = 2'd0;
    logic [31:0]               cfg_data  = 32'd0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [1:0]                action    = 2'd0;
    logic [RAW_W-1:0]          raw_count = '0;
    logic [TIME_W-1:0]         time_us   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [VEL_W-1:0]   velocity;
    logic                      velocity_saturated;

    // predictor copy of the registers and state
    logic [THRESH_W-1:0]     thr_cfg    = WRAP_THRESHOLD_RST;
    logic [LIMIT_W-1:0]      lim_cfg    = TURN_LIMIT_RST;
    logic [TIME_W-1:0]       max_iv_cfg = MAX_INTERVAL_RST;
    logic [TIME_W-1:0]       fb_cfg     = FALLBACK_RST;
    logic [RAW_W-1:0]        prev_raw   = '0;
    int                      turns      = 0;
    logic [LAST_ANGLE_W-1:0] ref_angle  = '0;
    logic [TIME_W-1:0]       ref_time   = '0;

    reading_t awaited[$];
    int       mismatches   = 0;
    int       results_seen = 0;
    int       n_sent       = 0;
    int       n_cfg        = 0;
    int       cycles       = 0;
    int       stall_mark   = 0;
    int       stall_left   = 0;
    bit       no_gaps      = 1'b0;

    encoder_multiturn_angle_velocity #(.RAW_BITS(RAW_W)) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .raw_count          (raw_count),
        .time_us            (time_us),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .angle              (angle),
        .velocity           (velocity),
        .velocity_saturated (velocity_saturated)
    );

    always #10 clk = ~clk;

    function automatic longint sext25(input logic [LAST_ANGLE_W-1:0] v);
        return longint'($signed(v));
    endfunction

    // Turn counting on one sample; a limit hit shifts the velocity reference angle.
    function automatic longint unwrap_turns(input logic [RAW_W-1:0] raw);
        int     d;
        int     mag;
        int     lim;
        longint shifted;
        d   = int'(raw) - int'(prev_raw);
        mag = (d < 0) ? -d : d;
        lim = int'(lim_cfg);
        if (mag >= int'(thr_cfg))
            turns += (d > 0) ? -1 : 1;
        prev_raw = raw;
        if (turns >= lim)
        begin
            turns     = 0;
            shifted   = sext25(ref_angle) - longint'(lim) * CPR;
            ref_angle = shifted[LAST_ANGLE_W-1:0];
        end
        if (turns <= -lim)
        begin
            turns     = 0;
            shifted   = sext25(ref_angle) + longint'(lim) * CPR;
            ref_angle = shifted[LAST_ANGLE_W-1:0];
        end
        return longint'(turns) * CPR + longint'(raw);
    endfunction

    function automatic reading_t estimate_reading(input action_t act,
                                                  input logic [RAW_W-1:0] raw,
                                                  input logic [TIME_W-1:0] now);
        longint            ang;
        longint            vel;
        longint            num;
        logic [TIME_W-1:0] dt;
        reading_t          r;
        ang         = 0;
        vel         = 0;
        r.saturated = 1'b0;
        case (act)
            ACT_INIT:
            begin
                prev_raw  = raw;
                turns     = 0;
                ref_time  = now;
                ref_angle = LAST_ANGLE_W'(raw);
                ang       = longint'(raw);
            end
            ACT_ANGLE:
                ang = unwrap_turns(raw);
            ACT_VELOCITY:
            begin
                // interval is taken before the unwrap
                dt = now - ref_time;
                if (dt == 0 || dt > max_iv_cfg)
                    dt = fb_cfg;
                if (dt == 0)
                    dt = 1;
                ang = unwrap_turns(raw);
                num = (ang - sext25(ref_angle)) * US_PER_SEC;
                vel = num / longint'({32'd0, dt});
                if (vel > INT32_TOP)
                begin
                    vel         = INT32_TOP;
                    r.saturated = 1'b1;
                end
                if (vel < INT32_BOTTOM)
                begin
                    vel         = INT32_BOTTOM;
                    r.saturated = 1'b1;
                end
                ref_angle = ang[LAST_ANGLE_W-1:0];
                ref_time  = now;
            end
            default:
                ang = longint'(turns) * CPR + longint'(prev_raw);
        endcase
        r.angle    = ang[ANGLE_W-1:0];
        r.velocity = vel[VEL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (result %0d, t=%0t)",
                 what, got, want, results_seen, $realtime);
        mismatches++;
    endtask

    task automatic send_request(input action_t act, input logic [RAW_W-1:0] raw,
                                input logic [TIME_W-1:0] stamp, input logic fixed,
                                input reading_t want);
        int       gap;
        reading_t r;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        action    <= act;
        raw_count <= raw;
        time_us   <= stamp;
        do @(posedge clk); while (in_stall);
        r = estimate_reading(act, raw, stamp);
        if (fixed)
            r = want;
        awaited.push_back(r);
        n_sent++;
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_WRAP_THRESHOLD: thr_cfg    = data[THRESH_W-1:0];
            REG_TURN_LIMIT:     lim_cfg    = data[LIMIT_W-1:0];
            REG_MAX_INTERVAL:   max_iv_cfg = data;
            REG_FALLBACK:       fb_cfg     = data;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic configure(input int phase);
        logic [31:0] thr;
        logic [31:0] lim;
        logic [31:0] max_iv;
        logic [31:0] fb;
        case (phase)
            1:       begin thr = 2048; lim = 1;    max_iv = 32'hFFFFFFFF; fb = 32'hFFFFFFFF; end
            2:       begin thr = 4095; lim = 2047; max_iv = 1;            fb = 1;            end
            3:       begin thr = 0;    lim = 0;    max_iv = 0;            fb = 0;            end
            4:
            begin
                thr    = $urandom_range(2048, 4095);
                lim    = $urandom_range(2, 6);
                max_iv = $urandom_range(1000, 600000);
                fb     = $urandom();
            end
            default: begin thr = 3277; lim = 3;    max_iv = 500000;       fb = 1000;         end
        endcase
        cfg_write(REG_WRAP_THRESHOLD, thr);
        cfg_write(REG_TURN_LIMIT, lim);
        cfg_write(REG_MAX_INTERVAL, max_iv);
        cfg_write(REG_FALLBACK, fb);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, awaited.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited.size() == 0)
                report_mismatch("unrequested result, angle", 32'(angle), 32'd0);
            else
            begin
                want = awaited.pop_front();
                if (angle !== want.angle)
                    report_mismatch("angle", 32'(angle), 32'(want.angle));
                if (velocity !== want.velocity)
                    report_mismatch("velocity", velocity, want.velocity);
                if (velocity_saturated !== want.saturated)
                    report_mismatch("saturated", 32'(velocity_saturated), 32'(want.saturated));
            end
            results_seen++;
        end
    end

    // receiver back-pressure: a fresh stall length after every result taken
    always @(negedge clk)
    begin
        if (results_seen != stall_mark)
        begin
            stall_mark = results_seen;
            stall_left = no_gaps ? 0 : $urandom_range(0, 9);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        logic [RAW_W-1:0]  rotor;
        logic [TIME_W-1:0] now;
        int                speed;
        int                pick;
        int                step;
        action_t           act;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(DIRECTED[i].act, DIRECTED[i].raw, DIRECTED[i].stamp,
                         DIRECTED[i].fixed, DIRECTED[i].want);

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                configure(phase);
            end
            no_gaps = (phase == 2);
            rotor   = RAW_W'($urandom_range(0, 4095));
            speed   = $urandom_range(0, 2400) - 1200;
            now     = $urandom();
            send_request(ACT_INIT, rotor, now, 1'b0, '0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_request(ACT_INIT, rotor, now, 1'b0, '0);
                else if (pick < 9)
                    send_request(ACT_HOLD, RAW_W'($urandom_range(0, 4095)), $urandom(),
                                 1'b0, '0);
                else if (pick < 17)
                    send_request(action_t'($urandom_range(0, 3)),
                                 RAW_W'($urandom_range(0, 4095)), $urandom(), 1'b0, '0);
                else
                begin
                    // well-formed motion: a turning rotor sampled at varying intervals
                    if ($urandom_range(0, 19) == 0)
                        speed = $urandom_range(0, 2400) - 1200;
                    rotor = RAW_W'(int'(rotor) + speed + $urandom_range(0, 80) - 40);
                    step  = $urandom_range(0, 99);
                    if (step < 70)
                        now = now + $urandom_range(1, 3000);
                    else if (step < 90)
                        now = now + $urandom_range(400000, 600000);
                    else if (step < 95)
                        now = $urandom();
                    act = $urandom_range(0, 1) ? ACT_VELOCITY : ACT_ANGLE;
                    send_request(act, rotor, now, 1'b0, '0);
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests (%0d directed), %0d results checked, %0d mismatches",
                 n_sent, N_DIRECTED, results_seen, mismatches);
        $display("%0d register writes over %0d settings incl. zero and all-ones values",
                 n_cfg, N_PHASES);
        if (mismatches == 0 && awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
